// ----- sv/gmcs_pkg.sv -----
// Shared types and constants of the graph coloring search block.
package gmcs_pkg;

    localparam int DEFAULT_MAX_VERTICES = 16;
    localparam int COLOR_LIMIT          = 16;
    localparam int COLOR_IW             = $clog2(COLOR_LIMIT);
    localparam int COLOR_W              = COLOR_IW + 1;
    localparam int CFG_W                = 5;
    localparam int CFG_IDX_W            = 1;
    localparam int OP_W                 = 2;
    localparam int VTX_FIELD_W          = 4;
    localparam int IN_DATA_W            = 16;
    localparam int OUT_DATA_W           = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_edge;
        logic clear_edges;
        logic start_search;
        logic search_step;
        logic emit_start;
        logic emit_next;
        logic report_fail;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic search_fail;
        logic emit_last;
    } sts_t;

endpackage

// ----- sv/gmcs_ctrl.sv -----
// Controller state machine of the graph coloring search block.
module gmcs_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gmcs_pkg::OP_W-1:0]   operation,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_tlast,
    output logic                        m_tuser,
    output gmcs_pkg::cmd_t              cmd,
    input  gmcs_pkg::sts_t              sts
);
    import gmcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT,
        ST_FAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   out_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT) || (state_reg == ST_FAIL);
    assign m_tuser  = (state_reg == ST_EMIT);
    assign m_tlast  = (state_reg == ST_FAIL) || sts.emit_last;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.report_fail = (state_reg == ST_FAIL);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (operation)
                        OP_ADD:   cmd.add_edge = 1'b1;
                        OP_CLEAR: cmd.clear_edges = 1'b1;
                        OP_SOLVE:
                        begin
                            cmd.start_search = 1'b1;
                            state_next       = ST_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.search_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (sts.search_fail)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_FAIL;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FAIL:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/gmcs_dp.sv -----
// Datapath: adjacency matrix, color store, color choice and result indexing.
module gmcs_dp
#(
    parameter int MAX_VERTICES = gmcs_pkg::DEFAULT_MAX_VERTICES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmcs_pkg::CFG_W-1:0]        cfg_data,
    input  logic [gmcs_pkg::VTX_FIELD_W-1:0]  vertex_a,
    input  logic [gmcs_pkg::VTX_FIELD_W-1:0]  vertex_b,
    input  gmcs_pkg::cmd_t                    cmd,
    output gmcs_pkg::sts_t                    sts,
    output logic [gmcs_pkg::VTX_FIELD_W-1:0]  vertex_index,
    output logic [gmcs_pkg::COLOR_IW-1:0]     color_index
);
    import gmcs_pkg::*;

    localparam int VIW = $clog2(MAX_VERTICES);

    logic [CFG_W-1:0]        num_vertices_reg;
    logic [CFG_W-1:0]        num_colors_reg;
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [COLOR_W-1:0]      color_reg [MAX_VERTICES];
    logic [VIW-1:0]          vtx_reg;
    logic [VIW-1:0]          emit_reg;

    logic [CFG_W-1:0]        n_eff;
    logic [CFG_W-1:0]        m_eff;
    logic                    edge_ok;
    logic [MAX_VERTICES-1:0] mask_a;
    logic [MAX_VERTICES-1:0] mask_b;
    logic [MAX_VERTICES-1:0] row;
    logic [COLOR_LIMIT-1:0]  used;
    logic [COLOR_W-1:0]      start_color;
    logic                    found;
    logic [COLOR_IW-1:0]     pick;
    logic                    at_last_vtx;

    // Effective counts: vertices saturate to the matrix size with zero taken as one,
    // colors saturate to the color limit.
    always_comb
    begin
        if (int'(num_vertices_reg) > MAX_VERTICES)
        begin
            n_eff = CFG_W'(MAX_VERTICES);
        end
        else if (num_vertices_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else
        begin
            n_eff = num_vertices_reg;
        end
        if (int'(num_colors_reg) > COLOR_LIMIT)
        begin
            m_eff = CFG_W'(COLOR_LIMIT);
        end
        else
        begin
            m_eff = num_colors_reg;
        end
    end

    assign edge_ok = (int'(vertex_a) < int'(n_eff)) && (int'(vertex_b) < int'(n_eff));

    // One-hot columns of the two endpoints; a row takes both when it is a self loop.
    assign mask_a = MAX_VERTICES'(1) << vertex_a;
    assign mask_b = MAX_VERTICES'(1) << vertex_b;

    // Colors held by neighbors of the current vertex. The vertex itself is skipped,
    // since it still holds its previous choice while retrying.
    assign row         = adj_reg[vtx_reg];
    assign start_color = color_reg[vtx_reg];

    always_comb
    begin
        used = '0;
        for (int u = 0; u < MAX_VERTICES; u++)
        begin
            if ((VIW'(u) != vtx_reg) && row[u] && (color_reg[u] != '0))
            begin
                used[COLOR_IW'(color_reg[u] - COLOR_W'(1))] = 1'b1;
            end
        end
    end

    // Lowest free color from the retry point upward.
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int k = 0; k < COLOR_LIMIT; k++)
        begin
            if (!found && (COLOR_W'(k) >= start_color) && (CFG_W'(k) < m_eff) && !used[k])
            begin
                found = 1'b1;
                pick  = COLOR_IW'(k);
            end
        end
    end

    assign at_last_vtx     = (int'(vtx_reg) + 1 == int'(n_eff));
    assign sts.search_done = found && at_last_vtx;
    assign sts.search_fail = !found && (vtx_reg == '0);
    assign sts.emit_last   = (int'(emit_reg) + 1 == int'(n_eff));

    assign vertex_index = cmd.report_fail ? '0 : VTX_FIELD_W'(emit_reg);
    assign color_index  = cmd.report_fail ? '0
                                          : COLOR_IW'(color_reg[emit_reg] - COLOR_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= CFG_W'(16);
            num_colors_reg   <= CFG_W'(3);
            vtx_reg          <= '0;
            emit_reg         <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i]   <= '0;
                color_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_VERTICES: num_vertices_reg <= cfg_data;
                    REG_NUM_COLORS:   num_colors_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.clear_edges)
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    adj_reg[i] <= '0;
                end
            end
            else if (cmd.add_edge && edge_ok)
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    adj_reg[i] <= adj_reg[i]
                                  | ((i == int'(vertex_a)) ? mask_b : '0)
                                  | ((i == int'(vertex_b)) ? mask_a : '0);
                end
            end

            if (cmd.start_search)
            begin
                vtx_reg <= '0;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    color_reg[i] <= '0;
                end
            end
            else if (cmd.search_step)
            begin
                if (found)
                begin
                    color_reg[vtx_reg] <= COLOR_W'(pick) + COLOR_W'(1);
                    if (!at_last_vtx)
                    begin
                        vtx_reg <= vtx_reg + VIW'(1);
                    end
                end
                else
                begin
                    color_reg[vtx_reg] <= '0;
                    if (vtx_reg != '0)
                    begin
                        vtx_reg <= vtx_reg - VIW'(1);
                    end
                end
            end

            if (cmd.emit_start)
            begin
                emit_reg <= '0;
            end
            else if (cmd.emit_next && !sts.emit_last)
            begin
                emit_reg <= emit_reg + VIW'(1);
            end
        end
    end

endmodule

// ----- sv/graph_m_coloring_search.sv -----
// Top level of the graph m-coloring backtracking search block.
//
//  Channel   Direction  Signals                         Contents
//  s_*       in         s_tvalid s_tready s_tdata       operation, vertex_a, vertex_b
//  m_*       out        m_tvalid m_tready m_tdata ...   vertex_index, color_index; solved, last
//  cfg_*     in         cfg_we cfg_index cfg_data       0 num_vertices, 1 num_colors
//
// Add and clear items may arrive back to back.
// A solve item runs the search step by step (each step one placement or one step back),
// then sends its results; s_tready stays low until the last result is taken.
// The result count is num_vertices (saturated, zero taken as one), or one when no coloring exists.
// Reset clears all edges, the color store and the registers to 16 vertices, 3 colors.
// A stalled m_tready holds the current result and the block waits.
module graph_m_coloring_search
#(
    parameter int MAX_VERTICES = gmcs_pkg::DEFAULT_MAX_VERTICES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] operation, [5:2] vertex_a, [9:6] vertex_b, [15:10] zero
    input  logic [gmcs_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] vertex_index, [7:4] color_index
    output logic [gmcs_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] solved
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [gmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmcs_pkg::CFG_W-1:0]        cfg_data
);
    import gmcs_pkg::*;

    cmd_t                   cmd;
    sts_t                   sts;
    logic [VTX_FIELD_W-1:0] vertex_index;
    logic [COLOR_IW-1:0]    color_index;

    gmcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (s_tdata[OP_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    gmcs_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .vertex_a     (s_tdata[OP_W +: VTX_FIELD_W]),
        .vertex_b     (s_tdata[OP_W+VTX_FIELD_W +: VTX_FIELD_W]),
        .cmd          (cmd),
        .sts          (sts),
        .vertex_index (vertex_index),
        .color_index  (color_index)
    );

    assign m_tdata = {color_index, vertex_index};

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the graph m-coloring backtracking search block.
`timescale 1ns / 100ps

module tb;
    import gmcs_pkg::*;

    localparam int SEARCH_BUDGET = 3000;
    localparam int STALL_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 290;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic       solved;
        logic [3:0] vertex;
        logic [3:0] color;
        logic       last;
    } coloring_result_t;

    typedef enum {ROW_ITEM, ROW_REG} row_kind_t;
    typedef enum {EXP_MODEL, EXP_UNIFORM, EXP_NO_COLORING} outcome_t;

    typedef struct {
        row_kind_t             kind;
        logic [OP_W-1:0]       op;
        logic [3:0]            a;
        logic [3:0]            b;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        outcome_t              outcome;
        int                    count;
        logic [3:0]            color;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // Local copy of the graph, color store and registers.
    logic [15:0]       adj_rows [16];
    logic [4:0]        color_store [16];
    logic [CFG_W-1:0]  vertex_reg;
    logic [CFG_W-1:0]  color_reg;

    coloring_result_t  colorings_due[$];
    stim_row_t         directed_rows[$];
    int                fail_count;
    int                quiet_cycles;
    bit                steady_flow;

    graph_m_coloring_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int vertices_in_use();
        int n;
        n = vertex_reg;
        if (n > 16)
            n = 16;
        if (n == 0)
            n = 1;
        return n;
    endfunction

    function automatic int colors_in_use();
        int m;
        m = color_reg;
        if (m > 16)
            m = 16;
        return m;
    endfunction

    function automatic bit color_is_free(int v, int c, int n);
        for (int u = 0; u < n; u++)
        begin
            if (u != v && adj_rows[v][u] && color_store[u] == 5'(c + 1))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Depth-first search; steps counts placements plus steps back.
    function automatic bit search_coloring(int n, int m, output int steps);
        int v;
        int c;
        bit placed;
        steps = 0;
        for (int i = 0; i < 16; i++)
            color_store[i] = '0;
        v = 0;
        while (v >= 0)
        begin
            steps++;
            c = color_store[v];
            placed = 1'b0;
            while (c < m && !placed)
            begin
                if (color_is_free(v, c, n))
                begin
                    color_store[v] = 5'(c + 1);
                    placed = 1'b1;
                end
                else
                    c++;
            end
            if (placed)
            begin
                if (v + 1 == n)
                    return 1'b1;
                v++;
            end
            else
            begin
                color_store[v] = '0;
                v--;
            end
        end
        return 1'b0;
    endfunction

    // Applies one item to the local copy; returns 1 unless the block ignores it.
    function automatic bit predict_item(logic [OP_W-1:0] op, logic [3:0] a, logic [3:0] b,
                                        bit push);
        int n;
        int steps;
        bit found;
        coloring_result_t r;
        n = vertices_in_use();
        case (op)
            OP_ADD:
            begin
                if (a >= n || b >= n)
                    return 1'b0;
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                return 1'b1;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < 16; i++)
                    adj_rows[i] = '0;
                return 1'b1;
            end
            OP_SOLVE:
            begin
                found = search_coloring(n, colors_in_use(), steps);
                if (push && !found)
                begin
                    r = '{solved: 1'b0, vertex: 4'd0, color: 4'd0, last: 1'b1};
                    colorings_due = {colorings_due, r};
                end
                else if (push)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.solved = 1'b1;
                        r.vertex = 4'(i);
                        r.color  = 4'(color_store[i] - 5'd1);
                        r.last   = (i + 1 == n);
                        colorings_due = {colorings_due, r};
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void add_item_row(logic [OP_W-1:0] op, logic [3:0] a, logic [3:0] b);
        stim_row_t row;
        row = '{kind: ROW_ITEM, op: op, a: a, b: b, reg_idx: '0, reg_val: '0,
                outcome: EXP_MODEL, count: 0, color: '0};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_typed_row(outcome_t outcome, int count, logic [3:0] color);
        stim_row_t row;
        row = '{kind: ROW_ITEM, op: OP_SOLVE, a: '0, b: '0, reg_idx: '0, reg_val: '0,
                outcome: outcome, count: count, color: color};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_REG, op: OP_ADD, a: '0, b: '0, reg_idx: idx, reg_val: val,
                outcome: EXP_MODEL, count: 0, color: '0};
        directed_rows = {directed_rows, row};
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] result mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [3:0] a,
                             input logic [3:0] b, input bit push, output bit effective);
        while (!steady_flow && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, b, a, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        effective = predict_item(op, a, b, push);
    endtask

    // Waits until every result has come, then lets a search that is still running end.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (colorings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_NUM_VERTICES)
            vertex_reg = val;
        else
            color_reg = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One setting of the registers, then a graph built from random edges and solved.
    task automatic random_phase(inout int count);
        int n_val;
        int m_val;
        int n_eff;
        int edge_total;
        int r;
        int steps;
        bit eff;
        logic [3:0] a;
        logic [3:0] b;
        steady_flow <= (count >= 120 && count < 200);
        r = $urandom_range(9);
        n_val = (r == 0) ? 16 : (r == 1) ? $urandom_range(31, 17) :
                (r == 2) ? $urandom_range(1) : $urandom_range(8, 2);
        r = $urandom_range(9);
        m_val = (r == 0) ? 16 : (r == 1) ? $urandom_range(31, 17) :
                (r == 2) ? 0 : $urandom_range(5, 1);
        settle();
        if ($urandom_range(1))
        begin
            write_reg(REG_NUM_VERTICES, 5'(n_val));
            write_reg(REG_NUM_COLORS, 5'(m_val));
        end
        else
        begin
            write_reg(REG_NUM_COLORS, 5'(m_val));
            write_reg(REG_NUM_VERTICES, 5'(n_val));
        end
        n_eff = vertices_in_use();
        if ($urandom_range(3) != 0)
        begin
            send_item(OP_CLEAR, 4'($urandom), 4'($urandom), 1'b1, eff);
            count += eff;
        end
        edge_total = $urandom_range(2 * n_eff + 2, 1);
        for (int k = 0; k < edge_total; k++)
        begin
            r = $urandom_range(19);
            a = 4'($urandom_range(n_eff - 1));
            b = 4'($urandom_range(n_eff - 1));
            if (r == 0)
                send_item(OP_UNUSED, 4'($urandom), 4'($urandom), 1'b1, eff);
            else if (r == 1)
                send_item(OP_ADD, 4'($urandom), 4'($urandom), 1'b1, eff);
            else if (r == 2)
                send_item(OP_ADD, a, a, 1'b1, eff);
            else
                send_item(OP_ADD, a, b, 1'b1, eff);
            count += eff;
        end
        repeat ($urandom_range(2, 1))
        begin
            // A graph whose search would run too long is cleared instead of solved.
            void'(search_coloring(n_eff, colors_in_use(), steps));
            if (steps > SEARCH_BUDGET)
                send_item(OP_CLEAR, 4'($urandom), 4'($urandom), 1'b1, eff);
            else
                send_item(OP_SOLVE, 4'($urandom), 4'($urandom), 1'b1, eff);
            count += eff;
        end
    endtask

    always @(posedge clk)
        m_tready <= steady_flow || ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin
        coloring_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (colorings_due.size() == 0)
                report_mismatch($sformatf("unexpected transfer, vertex %0d color %0d",
                                          m_tdata[3:0], m_tdata[7:4]));
            else
            begin
                want = colorings_due.pop_front();
                if (m_tuser !== want.solved)
                    report_mismatch($sformatf("solved %b, want %b", m_tuser, want.solved));
                if (m_tdata[3:0] !== want.vertex)
                    report_mismatch($sformatf("vertex %0d, want %0d",
                                              m_tdata[3:0], want.vertex));
                if (m_tdata[7:4] !== want.color)
                    report_mismatch($sformatf("color of vertex %0d is %0d, want %0d",
                                              want.vertex, m_tdata[7:4], want.color));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b on vertex %0d, want %b",
                                              m_tlast, want.vertex, want.last));
            end
        end
    end

    // Ends the run when nothing has moved on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bit eff;
        int random_count;
        coloring_result_t r;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        steady_flow = 1'b0;
        fail_count  = 0;
        quiet_cycles = 0;
        random_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            adj_rows[i]    = '0;
            color_store[i] = '0;
        end
        vertex_reg = 5'd16;
        color_reg  = 5'd3;

        // Empty graph after reset: every vertex takes the first color.
        add_typed_row(EXP_UNIFORM, 16, 4'd0);
        add_item_row(OP_UNUSED, 4'd15, 4'd15);
        add_item_row(OP_ADD, 4'd0, 4'd1);
        add_item_row(OP_ADD, 4'd1, 4'd2);
        add_item_row(OP_ADD, 4'd2, 4'd0);
        add_item_row(OP_ADD, 4'd15, 4'd14);
        add_item_row(OP_ADD, 4'd5, 4'd5);
        add_item_row(OP_ADD, 4'd9, 4'd12);
        add_item_row(OP_SOLVE, 4'd0, 4'd0);
        // Close a four-clique on vertices 0 to 3, which three colors cannot cover.
        add_item_row(OP_ADD, 4'd3, 4'd0);
        add_item_row(OP_ADD, 4'd1, 4'd3);
        add_item_row(OP_ADD, 4'd3, 4'd2);
        add_typed_row(EXP_NO_COLORING, 1, 4'd0);
        add_reg_row(REG_NUM_COLORS, 5'd4);
        add_item_row(OP_SOLVE, 4'd15, 4'd15);
        add_reg_row(REG_NUM_COLORS, 5'd0);
        add_typed_row(EXP_NO_COLORING, 1, 4'd0);
        add_reg_row(REG_NUM_COLORS, 5'd31);
        add_item_row(OP_SOLVE, 4'd0, 4'd0);
        add_item_row(OP_CLEAR, 4'd15, 4'd15);
        add_reg_row(REG_NUM_VERTICES, 5'd1);
        add_item_row(OP_ADD, 4'd0, 4'd0);
        add_item_row(OP_ADD, 4'd1, 4'd0);
        add_typed_row(EXP_UNIFORM, 1, 4'd0);
        add_reg_row(REG_NUM_VERTICES, 5'd0);
        add_typed_row(EXP_UNIFORM, 1, 4'd0);
        add_reg_row(REG_NUM_VERTICES, 5'd31);
        add_item_row(OP_ADD, 4'd15, 4'd0);
        add_item_row(OP_SOLVE, 4'd0, 4'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                          directed_rows[i].outcome == EXP_MODEL, eff);
                if (directed_rows[i].outcome == EXP_NO_COLORING)
                begin
                    r = '{solved: 1'b0, vertex: 4'd0, color: 4'd0, last: 1'b1};
                    colorings_due = {colorings_due, r};
                end
                else if (directed_rows[i].outcome == EXP_UNIFORM)
                begin
                    for (int k = 0; k < directed_rows[i].count; k++)
                    begin
                        r.solved = 1'b1;
                        r.vertex = 4'(k);
                        r.color  = directed_rows[i].color;
                        r.last   = (k + 1 == directed_rows[i].count);
                        colorings_due = {colorings_due, r};
                    end
                end
            end
        end

        while (random_count < RANDOM_ITEMS)
            random_phase(random_count);

        settle();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && colorings_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
